### src/cpba_pkg.sv
// ----------------------------------------------------------------------------
// cpba_pkg
// shared types and constants for the contiguous page bitmap allocator
// ----------------------------------------------------------------------------
package cpba_pkg;

   // request and result field widths
   localparam int OPERATION_W  = 1;
   localparam int PAGE_COUNT_W = 13;
   localparam int FREE_BASE_W  = 15;
   localparam int FIRST_PAGE_W = 15;

   // configuration register
   localparam int                CSR_DATA_W    = 32;
   localparam int                CSR_ADDR_W    = 3;
   localparam int                FSL_W         = 10;
   localparam logic              CSR_IDX_FSL   = 1'b0;
   localparam logic [FSL_W-1:0]  FSL_RESET     = 10'd1;

   // request operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // which result the datapath stages
   typedef enum logic [1:0] {
      RES_DONE,    // success, page zero
      RES_FAIL,    // failure, page zero
      RES_START,   // success, candidate start page
      RES_CAND     // success, first page of the found run
   } res_kind_type;

   // controller to datapath
   typedef struct packed {
      logic         load_req;
      logic         clear_step;
      logic         div_step;
      logic         free_setup;
      logic         scan_read;
      logic         scan_eval;
      logic         scan_bit;
      logic         set_setup;
      logic         rmw_read;
      logic         rmw_write;
      logic         res_write;
      res_kind_type res_kind;
      logic         rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic op_free;
      logic count_zero;
      logic start_oob;
      logic div_last;
      logic free_empty;
      logic scan_end;
      logic line_empty;
      logic line_partial;
      logic run_fits;
      logic bit_found;
      logic bit_last;
      logic rmw_last;
   } sts_type;

endpackage

### src/cpba_ram.sv
// ----------------------------------------------------------------------------
// cpba_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module cpba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/cpba_datapath.sv
// ----------------------------------------------------------------------------
// cpba_datapath
// bitmap ram, index divider, line scanner, read-modify-write and result regs
// ----------------------------------------------------------------------------
module cpba_datapath #(
   parameter int LINE_BITS  = 32,
   parameter int LINE_COUNT = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cpba_pkg::cmd_type                    cmd,
   output cpba_pkg::sts_type                    sts,
   input  logic [cpba_pkg::OPERATION_W-1:0]     req_operation,
   input  logic [cpba_pkg::PAGE_COUNT_W-1:0]    req_page_count,
   input  logic [cpba_pkg::FREE_BASE_W-1:0]     req_free_base,
   input  logic [cpba_pkg::FSL_W-1:0]           first_search_line,
   output logic                                 rsp_success,
   output logic [cpba_pkg::FIRST_PAGE_W-1:0]    rsp_first_page
);
   import cpba_pkg::*;

   localparam int LINE_W   = $clog2(LINE_COUNT);
   localparam int LCW      = LINE_W + 1;
   localparam int BIT_W    = $clog2(LINE_BITS);
   localparam int PG_W     = $clog2(LINE_BITS * LINE_COUNT + 1);
   localparam int RUN_W    = $clog2((1 << PAGE_COUNT_W) + LINE_BITS);
   localparam int RECIP_SH = FREE_BASE_W + BIT_W;
   localparam int RECIP_M  = ((1 << RECIP_SH) + LINE_BITS - 1) / LINE_BITS;
   localparam int RECIP_W  = FREE_BASE_W + 2;
   localparam int PROD_W   = FREE_BASE_W + RECIP_W;

   // registers
   logic [LINE_W-1:0]       clr_line_ff, clr_line_in;
   logic                    op_ff, op_in;
   logic [PAGE_COUNT_W-1:0] count_ff, count_in;
   logic [FREE_BASE_W-1:0]  div_num_ff, div_num_in;
   logic [FREE_BASE_W-1:0]  div_quo_ff, div_quo_in;
   logic [BIT_W-1:0]        div_rem_ff, div_rem_in;
   logic                    div_phase_ff, div_phase_in;
   logic [LCW-1:0]          scan_line_ff, scan_line_in;
   logic [PG_W-1:0]         scan_page_ff, scan_page_in;
   logic [PG_W-1:0]         cand_page_ff, cand_page_in;
   logic [LCW-1:0]          cand_line_ff, cand_line_in;
   logic [BIT_W-1:0]        cand_bit_ff, cand_bit_in;
   logic [RUN_W-1:0]        run_ff, run_in;
   logic [LINE_BITS-1:0]    word_ff, word_in;
   logic [BIT_W-1:0]        bit_ff, bit_in;
   logic [LCW-1:0]          rmw_line_ff, rmw_line_in;
   logic [BIT_W-1:0]        rmw_bit_ff, rmw_bit_in;
   logic [PAGE_COUNT_W-1:0] rmw_rem_ff, rmw_rem_in;
   logic                    rmw_set_ff, rmw_set_in;
   logic                    res_success_ff, res_success_in;
   logic [FIRST_PAGE_W-1:0] res_page_ff, res_page_in;
   logic                    rsp_success_ff, rsp_success_in;
   logic [FIRST_PAGE_W-1:0] rsp_page_ff, rsp_page_in;

   // ram side
   logic                    mem_wr_en;
   logic [LINE_W-1:0]       mem_wr_addr;
   logic [LINE_BITS-1:0]    mem_wr_data;
   logic                    mem_rd_en;
   logic [LINE_W-1:0]       mem_rd_addr;
   logic [LINE_BITS-1:0]    mem_rd_data;

   // combinational helpers
   logic [PROD_W-1:0]       div_prod;
   logic [FREE_BASE_W-1:0]  div_quo;
   logic [FREE_BASE_W-1:0]  div_back;
   logic [LINE_BITS-1:0]    rmw_mask;
   logic [LINE_BITS-1:0]    rmw_word;
   logic [RUN_W-1:0]        rmw_cover;
   logic                    line_empty;
   logic                    line_full;
   logic                    bit_used;
   logic                    bit_last;
   logic [FIRST_PAGE_W-1:0] start_page;

   cpba_ram #(
      .WIDTH (LINE_BITS),
      .DEPTH (LINE_COUNT)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // page index to line by reciprocal multiply, exact over the index range;
   // the bit within the line follows in the next cycle
   assign div_prod = PROD_W'(div_num_ff) * PROD_W'(RECIP_M);
   assign div_quo  = FREE_BASE_W'(div_prod >> RECIP_SH);
   assign div_back = div_quo_ff * FREE_BASE_W'(LINE_BITS);

   // bits from rmw_bit up to rmw_rem pages, within this line
   always_comb begin
      for (int j = 0; j < LINE_BITS; j++) begin
         rmw_mask[j] = (RUN_W'(j) >= RUN_W'(rmw_bit_ff)) &&
                       ((RUN_W'(j) - RUN_W'(rmw_bit_ff)) < RUN_W'(rmw_rem_ff));
      end
   end

   assign rmw_word  = rmw_set_ff ? (mem_rd_data | rmw_mask) : (mem_rd_data & ~rmw_mask);
   assign rmw_cover = RUN_W'(LINE_BITS) - RUN_W'(rmw_bit_ff);

   assign line_empty = (mem_rd_data == '0);
   assign line_full  = &mem_rd_data;
   assign bit_used   = word_ff[bit_ff];
   assign bit_last   = (bit_ff == BIT_W'(LINE_BITS - 1));
   assign start_page = FIRST_PAGE_W'(32'(first_search_line) * 32'(LINE_BITS));

   // status
   always_comb begin
      sts.clear_last   = (clr_line_ff == LINE_W'(LINE_COUNT - 1));
      sts.op_free      = (op_ff == OP_FREE);
      sts.count_zero   = (count_ff == '0);
      sts.start_oob    = (32'(first_search_line) >= 32'(LINE_COUNT));
      sts.div_last     = div_phase_ff;
      sts.free_empty   = (32'(div_quo_ff) >= 32'(LINE_COUNT)) || (count_ff == '0);
      sts.scan_end     = (scan_line_ff == LCW'(LINE_COUNT));
      sts.line_empty   = line_empty;
      sts.line_partial = !line_empty && !line_full;
      sts.run_fits     = (run_ff + RUN_W'(LINE_BITS)) >= RUN_W'(count_ff);
      sts.bit_found    = !bit_used && ((run_ff + 1'b1) == RUN_W'(count_ff));
      sts.bit_last     = bit_last;
      sts.rmw_last     = (rmw_cover >= RUN_W'(rmw_rem_ff)) ||
                         (rmw_line_ff == LCW'(LINE_COUNT - 1));
   end

   // ram ports
   assign mem_wr_en   = cmd.clear_step || cmd.rmw_write;
   assign mem_wr_addr = cmd.clear_step ? clr_line_ff : rmw_line_ff[LINE_W-1:0];
   assign mem_wr_data = cmd.clear_step ? '0 : rmw_word;
   assign mem_rd_en   = cmd.scan_read || cmd.rmw_read;
   assign mem_rd_addr = cmd.scan_read ? scan_line_ff[LINE_W-1:0] : rmw_line_ff[LINE_W-1:0];

   // next state
   always_comb begin
      clr_line_in    = clr_line_ff;
      op_in          = op_ff;
      count_in       = count_ff;
      div_num_in     = div_num_ff;
      div_quo_in     = div_quo_ff;
      div_rem_in     = div_rem_ff;
      div_phase_in   = div_phase_ff;
      scan_line_in   = scan_line_ff;
      scan_page_in   = scan_page_ff;
      cand_page_in   = cand_page_ff;
      cand_line_in   = cand_line_ff;
      cand_bit_in    = cand_bit_ff;
      run_in         = run_ff;
      word_in        = word_ff;
      bit_in         = bit_ff;
      rmw_line_in    = rmw_line_ff;
      rmw_bit_in     = rmw_bit_ff;
      rmw_rem_in     = rmw_rem_ff;
      rmw_set_in     = rmw_set_ff;
      res_success_in = res_success_ff;
      res_page_in    = res_page_ff;
      rsp_success_in = rsp_success_ff;
      rsp_page_in    = rsp_page_ff;

      if (cmd.clear_step) begin
         clr_line_in = clr_line_ff + 1'b1;
      end

      if (cmd.load_req) begin
         op_in        = req_operation[0];
         count_in     = req_page_count;
         div_num_in   = req_free_base;
         div_phase_in = 1'b0;
         scan_line_in = LCW'(first_search_line);
         scan_page_in = PG_W'(32'(first_search_line) * 32'(LINE_BITS));
         cand_page_in = PG_W'(32'(first_search_line) * 32'(LINE_BITS));
         cand_line_in = LCW'(first_search_line);
         cand_bit_in  = '0;
         run_in       = '0;
      end

      if (cmd.div_step) begin
         if (!div_phase_ff) begin
            div_quo_in = div_quo;
         end else begin
            div_rem_in = BIT_W'(div_num_ff - div_back);
         end
         div_phase_in = 1'b1;
      end

      if (cmd.free_setup) begin
         rmw_line_in = LCW'(div_quo_ff);
         rmw_bit_in  = div_rem_ff;
         rmw_rem_in  = count_ff;
         rmw_set_in  = 1'b0;
      end

      if (cmd.scan_eval) begin
         if (line_empty) begin
            run_in       = run_ff + RUN_W'(LINE_BITS);
            scan_line_in = scan_line_ff + 1'b1;
            scan_page_in = scan_page_ff + PG_W'(LINE_BITS);
         end else if (line_full) begin
            run_in       = '0;
            cand_page_in = scan_page_ff + PG_W'(LINE_BITS);
            cand_line_in = scan_line_ff + 1'b1;
            cand_bit_in  = '0;
            scan_line_in = scan_line_ff + 1'b1;
            scan_page_in = scan_page_ff + PG_W'(LINE_BITS);
         end else begin
            word_in = mem_rd_data;
            bit_in  = '0;
         end
      end

      if (cmd.scan_bit) begin
         if (bit_used) begin
            run_in       = '0;
            cand_page_in = scan_page_ff + PG_W'(bit_ff) + 1'b1;
            if (bit_last) begin
               cand_line_in = scan_line_ff + 1'b1;
               cand_bit_in  = '0;
            end else begin
               cand_line_in = scan_line_ff;
               cand_bit_in  = bit_ff + 1'b1;
            end
         end else begin
            run_in = run_ff + 1'b1;
         end
         if (bit_last) begin
            scan_line_in = scan_line_ff + 1'b1;
            scan_page_in = scan_page_ff + PG_W'(LINE_BITS);
         end else begin
            bit_in = bit_ff + 1'b1;
         end
      end

      if (cmd.set_setup) begin
         rmw_line_in = cand_line_ff;
         rmw_bit_in  = cand_bit_ff;
         rmw_rem_in  = count_ff;
         rmw_set_in  = 1'b1;
      end

      if (cmd.rmw_write) begin
         rmw_rem_in  = (RUN_W'(rmw_rem_ff) > rmw_cover) ?
                       PAGE_COUNT_W'(RUN_W'(rmw_rem_ff) - rmw_cover) : '0;
         rmw_line_in = rmw_line_ff + 1'b1;
         rmw_bit_in  = '0;
      end

      if (cmd.res_write) begin
         unique case (cmd.res_kind)
            RES_DONE: begin
               res_success_in = 1'b1;
               res_page_in    = '0;
            end
            RES_FAIL: begin
               res_success_in = 1'b0;
               res_page_in    = '0;
            end
            RES_START: begin
               res_success_in = 1'b1;
               res_page_in    = start_page;
            end
            RES_CAND: begin
               res_success_in = 1'b1;
               res_page_in    = FIRST_PAGE_W'(cand_page_ff);
            end
         endcase
      end

      if (cmd.rsp_load) begin
         rsp_success_in = res_success_ff;
         rsp_page_in    = res_page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_line_ff <= '0;
      end else begin
         clr_line_ff <= clr_line_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      count_ff       <= count_in;
      div_num_ff     <= div_num_in;
      div_quo_ff     <= div_quo_in;
      div_rem_ff     <= div_rem_in;
      div_phase_ff   <= div_phase_in;
      scan_line_ff   <= scan_line_in;
      scan_page_ff   <= scan_page_in;
      cand_page_ff   <= cand_page_in;
      cand_line_ff   <= cand_line_in;
      cand_bit_ff    <= cand_bit_in;
      run_ff         <= run_in;
      word_ff        <= word_in;
      bit_ff         <= bit_in;
      rmw_line_ff    <= rmw_line_in;
      rmw_bit_ff     <= rmw_bit_in;
      rmw_rem_ff     <= rmw_rem_in;
      rmw_set_ff     <= rmw_set_in;
      res_success_ff <= res_success_in;
      res_page_ff    <= res_page_in;
      rsp_success_ff <= rsp_success_in;
      rsp_page_ff    <= rsp_page_in;
   end

   assign rsp_success    = rsp_success_ff;
   assign rsp_first_page = rsp_page_ff;

endmodule

### src/cpba_controller.sv
// ----------------------------------------------------------------------------
// cpba_controller
// sequencer for clearing, free, allocate scan and bitmap update
// ----------------------------------------------------------------------------
module cpba_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cpba_pkg::cmd_type cmd,
   input  cpba_pkg::sts_type sts
);
   import cpba_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_DIV,
      ST_FREE_CHK,
      ST_SCAN_RD,
      ST_SCAN_EVAL,
      ST_SCAN_BIT,
      ST_SET,
      ST_RMW_RD,
      ST_RMW_WR,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd          = '0;
      cmd.res_kind = RES_DONE;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            priority if (sts.op_free) begin
               state_in = ST_DIV;
            end else if (sts.count_zero) begin
               cmd.res_write = 1'b1;
               cmd.res_kind  = RES_START;
               state_in      = ST_DONE;
            end else if (sts.start_oob) begin
               cmd.res_write = 1'b1;
               cmd.res_kind  = RES_FAIL;
               state_in      = ST_DONE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_FREE_CHK;
            end
         end
         ST_FREE_CHK: begin
            cmd.res_write = 1'b1;
            cmd.res_kind  = RES_DONE;
            if (sts.free_empty) begin
               state_in = ST_DONE;
            end else begin
               cmd.free_setup = 1'b1;
               state_in       = ST_RMW_RD;
            end
         end
         ST_SCAN_RD: begin
            if (sts.scan_end) begin
               cmd.res_write = 1'b1;
               cmd.res_kind  = RES_FAIL;
               state_in      = ST_DONE;
            end else begin
               cmd.scan_read = 1'b1;
               state_in      = ST_SCAN_EVAL;
            end
         end
         ST_SCAN_EVAL: begin
            cmd.scan_eval = 1'b1;
            priority if (sts.line_empty && sts.run_fits) begin
               state_in = ST_SET;
            end else if (sts.line_partial) begin
               state_in = ST_SCAN_BIT;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_BIT: begin
            cmd.scan_bit = 1'b1;
            priority if (sts.bit_found) begin
               state_in = ST_SET;
            end else if (sts.bit_last) begin
               state_in = ST_SCAN_RD;
            end else begin
               state_in = ST_SCAN_BIT;
            end
         end
         ST_SET: begin
            cmd.set_setup = 1'b1;
            cmd.res_write = 1'b1;
            cmd.res_kind  = RES_CAND;
            state_in      = ST_RMW_RD;
         end
         ST_RMW_RD: begin
            cmd.rmw_read = 1'b1;
            state_in     = ST_RMW_WR;
         end
         ST_RMW_WR: begin
            cmd.rmw_write = 1'b1;
            if (sts.rmw_last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_RMW_RD;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/contiguous_page_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_page_bitmap_allocator
// first fit allocator of contiguous page runs over a used-page bitmap
// ----------------------------------------------------------------------------
// usage
//   req channel (valid/ready): operation 0 allocates page_count contiguous
//   pages, searching upward from line first_search_line; operation 1 frees
//   page_count pages from free_base, pages past the bitmap are ignored
//   rsp channel (valid/ready): one item per request, success and first_page
//   csr port (apb style, pready always high): first_search_line at address 0
// timing
//   after reset a clearing pass writes every bitmap line to zero, one line a
//   cycle, with req_ready low; csr writes are taken as ever
//   free: the page index is split into line and bit, then each bitmap line
//   touched is read and written back; allocate: empty or full lines scanned
//   are passed whole, partly used lines bit by bit, then the run's lines are
//   marked used by read and write back; the single bitmap ram port and the
//   one-bit scan step bound the speed; one item is in work at a time; a
//   finished result sits in the output register, so the next item is
//   accepted while rsp waits, and its result is held back until the previous one is taken
// ----------------------------------------------------------------------------
module contiguous_page_bitmap_allocator #(
   parameter int LINE_BITS  = 32,
   parameter int LINE_COUNT = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [cpba_pkg::OPERATION_W-1:0]     req_operation,
   input  logic [cpba_pkg::PAGE_COUNT_W-1:0]    req_page_count,
   input  logic [cpba_pkg::FREE_BASE_W-1:0]     req_free_base,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_success,
   output logic [cpba_pkg::FIRST_PAGE_W-1:0]    rsp_first_page,
   // configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [cpba_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [cpba_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [cpba_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);
   import cpba_pkg::*;

   cmd_type          cmd;
   sts_type          sts;
   logic [FSL_W-1:0] fsl_ff, fsl_in;
   logic             csr_write;
   logic             csr_hit_fsl;

   // register index is the word address
   assign csr_hit_fsl = (paddr[CSR_ADDR_W-1:2] == CSR_IDX_FSL);
   assign csr_write   = psel && penable && pwrite && pready;
   assign pready      = 1'b1;

   assign fsl_in = (csr_write && csr_hit_fsl) ? pwdata[FSL_W-1:0] : fsl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fsl_ff <= FSL_RESET;
      end else begin
         fsl_ff <= fsl_in;
      end
   end

   // unmapped addresses read as zero
   assign prdata = csr_hit_fsl ? CSR_DATA_W'(fsl_ff) : '0;

   // sequencer
   cpba_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // bitmap storage, scanner and result registers
   cpba_datapath #(
      .LINE_BITS  (LINE_BITS),
      .LINE_COUNT (LINE_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_operation),
      .req_page_count    (req_page_count),
      .req_free_base     (req_free_base),
      .first_search_line (fsl_ff),
      .rsp_success       (rsp_success),
      .rsp_first_page    (rsp_first_page)
   );

endmodule

### tb/page_alloc_check_pkg.sv
// ----------------------------------------------------------------------------
// page_alloc_check_pkg
// scoreboard for the contiguous page bitmap allocator: keeps its own copy of
// the used-page bitmap and the search line, works out the result owed for
// every accepted request and compares each returned result in order
// ----------------------------------------------------------------------------
package page_alloc_check_pkg;

   timeunit 1ns;
   timeprecision 1ps;

   import cpba_pkg::*;

   localparam int unsigned LINE_BITS   = 32;
   localparam int unsigned LINE_COUNT  = 1024;
   localparam int unsigned TOTAL_PAGES = LINE_BITS * LINE_COUNT;
   localparam int unsigned REPORT_CAP  = 20;

   typedef struct packed {
      logic                    success;
      logic [FIRST_PAGE_W-1:0] first_page;
   } alloc_result_type;

   typedef struct {
      int unsigned base;
      int unsigned pages;
   } page_run_type;

   class page_alloc_scoreboard;
      logic [LINE_BITS-1:0] used_lines [LINE_COUNT];
      logic [FSL_W-1:0]     search_line;
      alloc_result_type     owed_results [$];
      page_run_type         live_runs [$];
      int unsigned          errors, checked, requests;
      int unsigned          fits, misses, zero_allocs, frees;

      function new();
         foreach (used_lines[i]) used_lines[i] = '0;
         search_line = FSL_RESET;
         errors      = 0;
         checked     = 0;
         requests    = 0;
         fits        = 0;
         misses      = 0;
         zero_allocs = 0;
         frees       = 0;
      endfunction

      function bit page_is_used(int unsigned page);
         return used_lines[page / LINE_BITS][page % LINE_BITS];
      endfunction

      function void mark_page(int unsigned page, bit used);
         used_lines[page / LINE_BITS][page % LINE_BITS] = used;
      endfunction

      function void set_search_line(logic [FSL_W-1:0] value);
         search_line = value;
      endfunction

      // hand out one allocated run for the stimulus to free
      function bit take_live_run(output page_run_type picked);
         int unsigned slot;
         if (live_runs.size() == 0) return 1'b0;
         slot   = $urandom_range(0, live_runs.size() - 1);
         picked = live_runs[slot];
         live_runs.delete(slot);
         return 1'b1;
      endfunction

      // apply one accepted request and queue the result it owes
      function void record_request(logic op, logic [PAGE_COUNT_W-1:0] count,
                                   logic [FREE_BASE_W-1:0] index);
         alloc_result_type owed;
         int unsigned      start, cand, run, p;
         bit               found;
         owed.success    = 1'b1;
         owed.first_page = '0;
         start           = search_line * LINE_BITS;
         requests++;
         if (op == OP_FREE) begin
            frees++;
            // pages past the end of the bitmap are dropped
            for (int unsigned i = 0; i < count; i++)
               if (index + i < TOTAL_PAGES) mark_page(index + i, 1'b0);
         end else if (count == 0) begin
            zero_allocs++;
            owed.first_page = FIRST_PAGE_W'(start);
         end else begin
            cand  = start;
            run   = 0;
            found = 1'b0;
            for (p = start; p < TOTAL_PAGES; p++) begin
               if (page_is_used(p)) begin
                  run  = 0;
                  cand = p + 1;
               end else begin
                  run++;
                  if (run == count) begin
                     found = 1'b1;
                     break;
                  end
               end
            end
            if (!found) begin
               misses++;
               owed.success = 1'b0;
            end else begin
               fits++;
               for (int unsigned i = 0; i < count; i++) mark_page(cand + i, 1'b1);
               owed.first_page = FIRST_PAGE_W'(cand);
               live_runs.push_back('{base: cand, pages: count});
            end
         end
         owed_results.push_back(owed);
      endfunction

      function void report_mismatch(string field, logic [31:0] want, logic [31:0] got);
         errors++;
         if (errors <= REPORT_CAP)
            $display("time %0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
      endfunction

      function void check_response(logic success, logic [FIRST_PAGE_W-1:0] first_page);
         alloc_result_type want;
         checked++;
         if (owed_results.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP)
               $display("time %0t: result with nothing owed, expected none, actual %0b/%0d",
                        $time, success, first_page);
            return;
         end
         want = owed_results.pop_front();
         if (success !== want.success)
            report_mismatch("success", 32'(want.success), 32'(success));
         if (first_page !== want.first_page)
            report_mismatch("first_page", 32'(want.first_page), 32'(first_page));
      endfunction
   endclass

endpackage

### tb/contiguous_page_bitmap_allocator_test.sv
// ----------------------------------------------------------------------------
// contiguous_page_bitmap_allocator_test
// self-checking bench: directed allocate and free requests, then random
// phases over several search-line settings, with bursty requests and a
// patterned result stall, every result checked against the scoreboard
// ----------------------------------------------------------------------------
module contiguous_page_bitmap_allocator_test;

   timeunit 1ns;
   timeprecision 1ps;

   import cpba_pkg::*;
   import page_alloc_check_pkg::*;

   // register map, one 32-bit register per 4 bytes
   localparam int unsigned              REG_STRIDE     = 4;
   localparam logic [CSR_ADDR_W-1:0]    FSL_ADDR       =
      CSR_ADDR_W'(int'(CSR_IDX_FSL) * REG_STRIDE);
   localparam logic [CSR_ADDR_W-1:0]    UNMAPPED_ADDR  = CSR_ADDR_W'(REG_STRIDE);

   localparam int unsigned              MAX_PAGE_COUNT = 4096;
   localparam int unsigned              MAX_LIVE_RUNS  = 16;
   localparam int unsigned              PHASE_COUNT    = 8;
   localparam int unsigned              RANDOM_ITEMS   = 1526;
   localparam int unsigned              HOLD_OFF       = 8;
   localparam int unsigned              TAIL_CYCLES    = 100;
   localparam int unsigned              WATCHDOG_LIMIT = 200000;

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_ready;
   logic [OPERATION_W-1:0]   req_operation  = '0;
   logic [PAGE_COUNT_W-1:0]  req_page_count = '0;
   logic [FREE_BASE_W-1:0]   req_free_base  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready      = 1'b0;
   logic                     rsp_success;
   logic [FIRST_PAGE_W-1:0]  rsp_first_page;
   logic                     psel           = 1'b0;
   logic                     penable        = 1'b0;
   logic                     pwrite         = 1'b0;
   logic [CSR_ADDR_W-1:0]    paddr          = '0;
   logic [CSR_DATA_W-1:0]    pwdata         = '0;
   logic [CSR_DATA_W-1:0]    prdata;
   logic                     pready;

   page_alloc_scoreboard sb = new();

   contiguous_page_bitmap_allocator #(
      .LINE_BITS  (LINE_BITS),
      .LINE_COUNT (LINE_COUNT)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_page_count (req_page_count),
      .req_free_base  (req_free_base),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_success    (rsp_success),
      .rsp_first_page (rsp_first_page),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // result side stall: a 16-bit ready pattern that rotates and is
   // redrawn every few turns, from always ready down to a single ready bit
   logic [15:0] ready_pattern = '1;
   int unsigned pattern_left  = 0;

   always @(posedge clock) begin
      if (pattern_left == 0) begin
         pattern_left <= 16 * $urandom_range(1, 8);
         case ($urandom_range(0, 3))
            0: begin
               ready_pattern <= '1;
            end
            1: begin
               ready_pattern <= 16'($urandom);
            end
            2: begin
               ready_pattern <= 16'(1) << $urandom_range(0, 15);
            end
            default: begin
               ready_pattern <= 16'($urandom) | 16'($urandom);
            end
         endcase
      end else begin
         pattern_left  <= pattern_left - 1;
         ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      end
      rsp_ready <= ready_pattern[0];
   end

   // every accepted result goes straight to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_success, rsp_first_page);
   end

   // watchdog on cycles where neither channel moves an item
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("time %0t: watchdog, %0d cycles with no item accepted", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // present one request and hold it until accepted; valid stays high so a
   // following request can go out back to back
   task automatic issue_request(logic op, logic [PAGE_COUNT_W-1:0] count,
                                logic [FREE_BASE_W-1:0] index);
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_page_count <= count;
      req_free_base  <= index;
      do @(posedge clock); while (!req_ready);
      sb.record_request(op, count, index);
   endtask

   task automatic idle_sender(int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // stop sending until every owed result is back, then let the block settle
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.owed_results.size() != 0) @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   // apb write, then read the search line back in the next transfer
   task automatic program_register(logic [CSR_ADDR_W-1:0] addr,
                                   logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      // an address past the register list changes nothing
      if (addr == FSL_ADDR) sb.set_search_line(data[FSL_W-1:0]);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= FSL_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DATA_W'(sb.search_line)) begin
         sb.errors++;
         $display("time %0t: search line readback mismatch, expected %0d, actual %0d",
                  $time, sb.search_line, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // directed requests, run at the reset search line
   task automatic run_directed_checks();
      // zero count gives the candidate start and marks nothing
      issue_request(OP_ALLOC, '0, '0);
      // page index has no effect on allocate
      issue_request(OP_ALLOC, PAGE_COUNT_W'(1), '1);
      // fill the rest of the start line so the scan must step over a full line
      issue_request(OP_ALLOC, PAGE_COUNT_W'(31), '0);
      issue_request(OP_ALLOC, PAGE_COUNT_W'(5), '0);
      // hole inside a used line, found by the bit-by-bit scan
      issue_request(OP_FREE, PAGE_COUNT_W'(3), FREE_BASE_W'(40));
      issue_request(OP_ALLOC, PAGE_COUNT_W'(3), '0);
      // largest runs until the end of the bitmap is reached without a fit
      repeat (8) issue_request(OP_ALLOC, PAGE_COUNT_W'(MAX_PAGE_COUNT), '0);
      // free that runs past the last page, and an empty free
      issue_request(OP_FREE, PAGE_COUNT_W'(MAX_PAGE_COUNT), '1);
      issue_request(OP_FREE, '0, '0);
      // clear the whole bitmap again
      for (int unsigned k = 0; k < 8; k++)
         issue_request(OP_FREE, PAGE_COUNT_W'(MAX_PAGE_COUNT),
                       FREE_BASE_W'(k * MAX_PAGE_COUNT));
   endtask

   // mostly allocate / free-what-was-allocated traffic, some stray frees
   task automatic issue_random_request();
      page_run_type             run;
      logic [PAGE_COUNT_W-1:0]  count;
      logic [FREE_BASE_W-1:0]   index;
      int unsigned              pick;
      pick  = $urandom_range(0, 99);
      index = FREE_BASE_W'($urandom);
      // small counts dominate, a few up to the largest
      case ($urandom_range(0, 19))
         0: begin
            count = '0;
         end
         1: begin
            count = PAGE_COUNT_W'(MAX_PAGE_COUNT);
         end
         2, 3: begin
            count = PAGE_COUNT_W'($urandom_range(65, MAX_PAGE_COUNT - 1));
         end
         4, 5, 6: begin
            count = PAGE_COUNT_W'($urandom_range(33, 64));
         end
         default: begin
            count = PAGE_COUNT_W'($urandom_range(1, 32));
         end
      endcase
      if ((sb.live_runs.size() >= MAX_LIVE_RUNS || pick < 35) && sb.take_live_run(run))
         issue_request(OP_FREE, PAGE_COUNT_W'(run.pages), FREE_BASE_W'(run.base));
      else if (pick < 45)
         issue_request(OP_FREE, count, index);
      else
         issue_request(OP_ALLOC, count, index);
   endtask

   // bursts of random length with random gaps, some bursts back to back
   task automatic run_random_phase(int unsigned items);
      int unsigned sent, burst;
      sent = 0;
      while (sent < items) begin
         burst = $urandom_range(1, 12);
         for (int unsigned k = 0; k < burst && sent < items; k++) begin
            issue_random_request();
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 9));
      end
   endtask

   initial begin
      logic [FSL_W-1:0] phase_lines [PHASE_COUNT];
      int unsigned      per_phase;
      phase_lines[0] = 10'd0;
      phase_lines[1] = 10'd1023;
      phase_lines[2] = FSL_W'($urandom);
      phase_lines[3] = FSL_RESET;
      phase_lines[4] = 10'd512;
      phase_lines[5] = 10'd1022;
      phase_lines[6] = FSL_W'($urandom);
      phase_lines[7] = 10'd0;
      per_phase      = RANDOM_ITEMS / PHASE_COUNT;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      run_directed_checks();

      for (int unsigned ph = 0; ph < PHASE_COUNT; ph++) begin
         drain_results();
         if (ph == 3) begin
            // write past the register list, search line must not move
            program_register(UNMAPPED_ADDR, '1);
            drain_results();
         end
         program_register(FSL_ADDR, CSR_DATA_W'(phase_lines[ph]));
         // pause halfway until every owed result is back
         run_random_phase(per_phase / 2);
         drain_results();
         run_random_phase(per_phase - per_phase / 2);
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.owed_results.size() != 0) begin
         sb.errors++;
         $display("time %0t: results still owed, expected 0, actual %0d",
                  $time, sb.owed_results.size());
      end

      $display("%0d requests, %0d search lines: %0d placed, %0d no fit, %0d zero, %0d frees",
               sb.requests, PHASE_COUNT + 1, sb.fits, sb.misses, sb.zero_allocs, sb.frees);
      $display("%0d results compared, %0d errors", sb.checked, sb.errors);
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
